// ===== rtl/pid_feedback_controller_multi_axis_core_assert.svh =====
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Concurrent checks clocked by clk_i and disabled while rst_ni is low.
// The macros expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef PID_FEEDBACK_CONTROLLER_MULTI_AXIS_CORE_ASSERT_SVH
`define PID_FEEDBACK_CONTROLLER_MULTI_AXIS_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define PIDFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pidfc assertion failed");
// condition must never be true at a clock edge out of reset
`define PIDFC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("pidfc forbidden condition seen");
`else
`define PIDFC_ASSERT(lbl, prop)
`define PIDFC_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== rtl/pidfc_pkg.sv =====
// ----------------------------------------------------------------------------
// PID controller package
// Shared widths, register indexes and transaction payload types.
// ----------------------------------------------------------------------------
package pidfc_pkg;

  // axes in use and payload slots
  localparam int NumAxes   = 4;
  localparam int AxisSlots = 4;
  localparam int AxisW     = 2;

  // fixed point format
  localparam int FracBits = 16;
  localparam int DataW    = 32;
  localparam int AccW     = 48;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgGainP = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGainI = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGainD = 2'd2;

  typedef struct packed {
    logic signed [DataW-1:0] current_pos_0;
    logic signed [DataW-1:0] current_pos_1;
    logic signed [DataW-1:0] current_pos_2;
    logic signed [DataW-1:0] current_pos_3;
    logic signed [DataW-1:0] target_pos_0;
    logic signed [DataW-1:0] target_pos_1;
    logic signed [DataW-1:0] target_pos_2;
    logic signed [DataW-1:0] target_pos_3;
    logic        [DataW-1:0] time_step;
  } pidfc_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] force_0;
    logic signed [DataW-1:0] force_1;
    logic signed [DataW-1:0] force_2;
    logic signed [DataW-1:0] force_3;
  } pidfc_out_t;

endpackage

// ===== rtl/pidfc_in_if.sv =====
// ----------------------------------------------------------------------------
// PID controller input channel
// Valid/ready channel carrying positions, targets and the time step.
// ----------------------------------------------------------------------------
interface pidfc_in_if import pidfc_pkg::*; ();
  logic      valid;
  logic      ready;
  pidfc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pidfc_out_if.sv =====
// ----------------------------------------------------------------------------
// PID controller output channel
// Valid/ready channel carrying the per-axis drive values.
// ----------------------------------------------------------------------------
interface pidfc_out_if import pidfc_pkg::*; ();
  logic       valid;
  logic       ready;
  pidfc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pid_feedback_controller_multi_axis_core.sv =====
// ----------------------------------------------------------------------------
// PID feedback controller core, four axes
// Per axis: four multiplies on a shared 17x33 multiplier, plus a 49-step divider
// for the derivative unless the time step is zero. One transaction in flight at
// a time, so the next one is accepted only once the result of the last has been
// loaded into the output register, later on output stall.
// Reset clears gains, stored targets, integrals and previous errors at once.
// ----------------------------------------------------------------------------
`include "pid_feedback_controller_multi_axis_core_assert.svh"

module pid_feedback_controller_multi_axis_core import pidfc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_wdata_i,
  pidfc_in_if.sink           in_i,
  pidfc_out_if.source        out_o
);

  // shared multiplier: A operand split in 16-bit chunks, B is 33-bit signed
  localparam int MulChunkW = 16;
  localparam int MulChunks = AccW / MulChunkW;
  localparam int MulCntW   = $clog2(MulChunks + 1);
  localparam int MulBW     = DataW + 1;
  localparam int PpW       = MulChunkW + 1 + MulBW;
  localparam int ProdW     = AccW + MulBW;
  // restoring divider on the scaled error difference
  localparam int DivW      = DataW + 1 + FracBits;
  localparam int DivCntW   = $clog2(DivW);
  localparam int SumW      = AccW + 1;
  localparam int ForceW    = AccW + 2;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHECK  = 9'b000000010,
    S_ERR    = 9'b000000100,
    S_MUL    = 9'b000001000,
    S_POST   = 9'b000010000,
    S_DIV    = 9'b000100000,
    S_DIVFIN = 9'b001000000,
    S_AXWB   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  typedef enum logic [1:0] {
    OP_ITG = 2'd0,
    OP_P   = 2'd1,
    OP_I   = 2'd2,
    OP_D   = 2'd3
  } op_e;

  // saturate a full product down to the accumulator width
  function automatic logic [AccW-1:0] sat_prod(input logic [ProdW-1:0] v);
    logic in_range;
    in_range = (&v[ProdW-1:AccW-1]) || !(|v[ProdW-1:AccW-1]);
    if (in_range) return v[AccW-1:0];
    else if (v[ProdW-1]) return {1'b1, {(AccW-1){1'b0}}};
    else return {1'b0, {(AccW-1){1'b1}}};
  endfunction

  function automatic logic [AccW-1:0] sat_sum(input logic [SumW-1:0] v);
    if (v[SumW-1] == v[SumW-2]) return v[AccW-1:0];
    else if (v[SumW-1]) return {1'b1, {(AccW-1){1'b0}}};
    else return {1'b0, {(AccW-1){1'b1}}};
  endfunction

  function automatic logic [DataW-1:0] sat_force(input logic [ForceW-1:0] v);
    logic in_range;
    in_range = (&v[ForceW-1:DataW-1]) || !(|v[ForceW-1:DataW-1]);
    if (in_range) return v[DataW-1:0];
    else if (v[ForceW-1]) return {1'b1, {(DataW-1){1'b0}}};
    else return {1'b0, {(DataW-1){1'b1}}};
  endfunction

  state_e state_q, state_d;
  op_e    op_q;

  logic [AxisW-1:0]   axis_q;
  logic [MulCntW-1:0] mul_cnt_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic               out_valid_q;
  logic               tgt_known_q;

  logic [DataW-1:0] gain_p_q, gain_i_q, gain_d_q;

  logic [DataW-1:0] cur_q    [AxisSlots];
  logic [DataW-1:0] tgt_in_q [AxisSlots];
  logic [DataW-1:0] tgt_q    [AxisSlots];
  logic [DataW-1:0] prev_q   [AxisSlots];
  logic [AccW-1:0]  integ_q  [AxisSlots];
  logic [DataW-1:0] force_q  [AxisSlots];
  logic [DataW-1:0] dt_q;

  logic [DataW-1:0]         err_q;
  logic [AccW-1:0]          integ_new_q;
  logic [AccW-1:0]          deriv_q;
  logic [AccW-1:0]          mul_a_q;
  logic signed [MulBW-1:0]  mul_b_q;
  logic signed [PpW-1:0]    pp_q;
  logic signed [ProdW-1:0]  acc_q;
  logic [ForceW-1:0]        force_acc_q;
  logic [DataW-1:0]         div_rem_q;
  logic [DivW-1:0]          div_dvd_q;
  logic                     div_neg_q;
  pidfc_out_t               out_data_q;

  // target change detection over the active axes
  logic changed_c;
  always_comb begin
    changed_c = !tgt_known_q;
    for (int a = 0; a < AxisSlots; a++) begin
      if ((a < NumAxes) && (tgt_in_q[a] != tgt_q[a])) changed_c = 1'b1;
    end
  end

  // error of the current axis, saturated to 32 bits
  logic [DataW:0]   err_wide;
  logic [DataW-1:0] err_c;
  assign err_wide = {tgt_q[axis_q][DataW-1], tgt_q[axis_q]}
                  - {cur_q[axis_q][DataW-1], cur_q[axis_q]};
  assign err_c = (err_wide[DataW] == err_wide[DataW-1]) ? err_wide[DataW-1:0] :
                 (err_wide[DataW] ? {1'b1, {(DataW-1){1'b0}}}
                                  : {1'b0, {(DataW-1){1'b1}}});

  // multiplier chunk select; the top chunk carries the sign
  logic [MulCntW-1:0]         chunk_idx;
  logic [MulChunkW-1:0]       chunk_bits;
  logic signed [MulChunkW:0]  chunk_s;
  logic signed [PpW-1:0]      pp_c;
  logic signed [ProdW-1:0]    pp_ext;
  logic [MulCntW-1:0]         acc_pos;
  logic signed [ProdW-1:0]    acc_add;
  assign chunk_idx  = (mul_cnt_q < MulCntW'(MulChunks)) ? mul_cnt_q
                                                        : MulCntW'(MulChunks - 1);
  assign chunk_bits = mul_a_q[chunk_idx*MulChunkW +: MulChunkW];
  assign chunk_s    = {(chunk_idx == MulCntW'(MulChunks - 1)) ? chunk_bits[MulChunkW-1]
                                                               : 1'b0, chunk_bits};
  assign pp_c       = chunk_s * mul_b_q;
  assign pp_ext     = ProdW'(pp_q);
  assign acc_pos    = mul_cnt_q - MulCntW'(1);
  assign acc_add    = acc_q + (pp_ext <<< (int'(acc_pos) * MulChunkW));

  // product scaled back by the fraction bits, floor rounding
  logic signed [ProdW-1:0] prod_shift;
  logic [AccW-1:0]         prod_sat;
  assign prod_shift = acc_q >>> FracBits;
  assign prod_sat   = sat_prod(prod_shift);

  // integral update
  logic [SumW-1:0] integ_sum;
  logic [AccW-1:0] integ_sat;
  assign integ_sum = {integ_q[axis_q][AccW-1], integ_q[axis_q]} + {prod_sat[AccW-1], prod_sat};
  assign integ_sat = sat_sum(integ_sum);

  // derivative numerator: error difference as sign and magnitude
  logic [DataW:0] dnum;
  logic [DataW:0] dmag;
  assign dnum = {err_q[DataW-1], err_q} - {prev_q[axis_q][DataW-1], prev_q[axis_q]};
  assign dmag = dnum[DataW] ? (~dnum + 1'b1) : dnum;

  // one restoring divide step
  logic [DataW:0]   div_shift;
  logic [DataW+1:0] div_diff;
  logic             div_ge;
  logic [DataW-1:0] div_rem_c;
  assign div_shift = {div_rem_q, div_dvd_q[DivW-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, dt_q};
  assign div_ge    = !div_diff[DataW+1];
  assign div_rem_c = div_ge ? div_diff[DataW-1:0] : div_shift[DataW-1:0];

  // signed quotient, truncated toward zero
  logic [ProdW-1:0] q_ext;
  logic [ProdW-1:0] q_signed;
  logic [AccW-1:0]  deriv_c;
  assign q_ext    = ProdW'(div_dvd_q);
  assign q_signed = div_neg_q ? (~q_ext + 1'b1) : q_ext;
  assign deriv_c  = sat_prod(q_signed);

  // force accumulation
  logic [ForceW-1:0] term_ext;
  logic [ForceW-1:0] force_sum_c;
  assign term_ext    = {{(ForceW-AccW){prod_sat[AccW-1]}}, prod_sat};
  assign force_sum_c = force_acc_q + term_ext;

  logic load_out;
  assign load_out = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_i.valid) state_d = S_CHECK;
      S_CHECK:  state_d = S_ERR;
      S_ERR:    state_d = S_MUL;
      S_MUL:    if (mul_cnt_q == MulCntW'(MulChunks)) state_d = S_POST;
      S_POST: begin
        unique case (op_q)
          OP_ITG:  state_d = (dt_q == '0) ? S_MUL : S_DIV;
          OP_P:    state_d = S_MUL;
          OP_I:    state_d = S_MUL;
          OP_D:    state_d = S_AXWB;
          default: state_d = S_IDLE;
        endcase
      end
      S_DIV:    if (div_cnt_q == DivCntW'(DivW - 1)) state_d = S_DIVFIN;
      S_DIVFIN: state_d = S_MUL;
      S_AXWB:   state_d = (axis_q == AxisW'(NumAxes - 1)) ? S_DONE : S_ERR;
      S_DONE:   if (load_out) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // control state, gains and per-axis controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_ITG;
      axis_q      <= '0;
      mul_cnt_q   <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      tgt_known_q <= 1'b0;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      for (int a = 0; a < AxisSlots; a++) begin
        tgt_q[a]   <= '0;
        prev_q[a]  <= '0;
        integ_q[a] <= '0;
      end
    end else begin
      state_q <= state_d;

      // gain register writes; unknown indexes are dropped
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgGainP: gain_p_q <= cfg_wdata_i;
          CfgGainI: gain_i_q <= cfg_wdata_i;
          CfgGainD: gain_d_q <= cfg_wdata_i;
          default:  ;
        endcase
      end

      // result register handshake
      if (load_out) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;

      unique case (state_q)
        S_CHECK: begin
          if (changed_c) begin
            for (int a = 0; a < AxisSlots; a++) begin
              tgt_q[a]   <= (a < NumAxes) ? tgt_in_q[a] : '0;
              prev_q[a]  <= '0;
              integ_q[a] <= '0;
            end
            tgt_known_q <= 1'b1;
          end
          axis_q <= '0;
        end
        S_ERR: begin
          op_q      <= OP_ITG;
          mul_cnt_q <= '0;
        end
        S_MUL:  mul_cnt_q <= mul_cnt_q + 1'b1;
        S_POST: begin
          mul_cnt_q <= '0;
          div_cnt_q <= '0;
          unique case (op_q)
            OP_ITG: begin
              integ_q[axis_q] <= integ_sat;
              op_q            <= OP_P;
            end
            OP_P:    op_q <= OP_I;
            OP_I:    op_q <= OP_D;
            default: ;
          endcase
        end
        S_DIV:  div_cnt_q <= div_cnt_q + 1'b1;
        S_AXWB: begin
          prev_q[axis_q] <= err_q;
          if (axis_q != AxisW'(NumAxes - 1)) axis_q <= axis_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q.force_0 <= force_q[0];
      out_data_q.force_1 <= force_q[1];
      out_data_q.force_2 <= force_q[2];
      out_data_q.force_3 <= force_q[3];
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cur_q[0]    <= in_i.data.current_pos_0;
          cur_q[1]    <= in_i.data.current_pos_1;
          cur_q[2]    <= in_i.data.current_pos_2;
          cur_q[3]    <= in_i.data.current_pos_3;
          tgt_in_q[0] <= in_i.data.target_pos_0;
          tgt_in_q[1] <= in_i.data.target_pos_1;
          tgt_in_q[2] <= in_i.data.target_pos_2;
          tgt_in_q[3] <= in_i.data.target_pos_3;
          dt_q        <= in_i.data.time_step;
        end
      end
      S_CHECK: begin
        for (int a = 0; a < AxisSlots; a++) force_q[a] <= '0;
      end
      S_ERR: begin
        err_q   <= err_c;
        mul_a_q <= {{(AccW-DataW){err_c[DataW-1]}}, err_c};
        mul_b_q <= {1'b0, dt_q};
        acc_q   <= '0;
      end
      S_MUL: begin
        if (mul_cnt_q < MulCntW'(MulChunks)) pp_q <= pp_c;
        if (mul_cnt_q != '0) acc_q <= acc_add;
      end
      S_POST: begin
        acc_q <= '0;
        unique case (op_q)
          OP_ITG: begin
            integ_new_q <= integ_sat;
            div_rem_q   <= '0;
            div_dvd_q   <= {dmag, {FracBits{1'b0}}};
            div_neg_q   <= dnum[DataW];
            deriv_q     <= '0;
            mul_a_q     <= {{(AccW-DataW){err_q[DataW-1]}}, err_q};
            mul_b_q     <= {gain_p_q[DataW-1], gain_p_q};
          end
          OP_P: begin
            force_acc_q <= term_ext;
            mul_a_q     <= integ_new_q;
            mul_b_q     <= {gain_i_q[DataW-1], gain_i_q};
          end
          OP_I: begin
            force_acc_q <= force_sum_c;
            mul_a_q     <= deriv_q;
            mul_b_q     <= {gain_d_q[DataW-1], gain_d_q};
          end
          OP_D:    force_acc_q <= force_sum_c;
          default: ;
        endcase
      end
      S_DIV: begin
        div_rem_q <= div_rem_c;
        div_dvd_q <= {div_dvd_q[DivW-2:0], div_ge};
      end
      S_DIVFIN: deriv_q <= deriv_c;
      S_AXWB:   force_q[axis_q] <= sat_force(force_acc_q);
      default:  ;
    endcase
  end

  // checks
  `PIDFC_ASSERT(busy_after_accept_a, in_i.valid && in_i.ready |=> !in_i.ready)
  `PIDFC_ASSERT(out_from_done_a, $rose(out_valid_q) |-> $past(state_q == S_DONE))
  `PIDFC_ASSERT(axis_in_range_a, axis_q <= AxisW'(NumAxes - 1))
  `PIDFC_ASSERT(mul_cnt_range_a, state_q == S_MUL |-> mul_cnt_q <= MulCntW'(MulChunks))
  `PIDFC_ASSERT_NEVER(div_zero_step_a, state_q == S_DIV && dt_q == '0)

endmodule
